// File: rtl/qte_pkg.sv
// shared types, widths and constants for the quaternion to euler angle pipeline
package qte_pkg;

  localparam int QW      = 16;  // quaternion component width
  localparam int PW      = 32;  // product width
  localparam int TW      = 34;  // rotation matrix term width, q28
  localparam int SW      = 30;  // saturated sine width, q28
  localparam int RADW    = 57;  // square root radicand width
  localparam int ROOTW   = 29;  // square root width
  localparam int NW      = 40;  // normalized operand width
  localparam int CW      = 43;  // cordic x/y width
  localparam int ZW      = 34;  // cordic angle accumulator width, q30
  localparam int AW      = 16;  // output angle width, q13
  localparam int YAWW    = 15;  // yaw output width
  localparam int SQRT_STEPS   = 29;
  localparam int CORDIC_STEPS = 20;
  localparam int ATAN_LAT     = CORDIC_STEPS + 5;

  localparam logic signed [AW-1:0] PiQ13     = 16'sd25736;
  localparam logic signed [AW-1:0] HalfPiQ13 = 16'sd12868;
  localparam logic signed [ZW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [SW-1:0] OneQ28    = 30'sd268435456;

  typedef enum logic [2:0] {
    KIND_CORDIC,
    KIND_ZERO,
    KIND_PI,
    KIND_POS_HALF,
    KIND_NEG_HALF
  } atan_kind_e;

  typedef struct packed {
    logic signed [TW-1:0] t00;
    logic signed [TW-1:0] t10;
    logic signed [TW-1:0] t21;
    logic signed [TW-1:0] t22;
    logic signed [SW-1:0] sine;
    logic                 clipped;
  } terms_t;

  function automatic logic signed [ZW-1:0] atan_q30(int idx);
    logic signed [ZW-1:0] r;
    case (idx)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048576;
      11: r = 34'sd524288;
      12: r = 34'sd262144;
      13: r = 34'sd131072;
      14: r = 34'sd65536;
      15: r = 34'sd32768;
      16: r = 34'sd16384;
      17: r = 34'sd8192;
      18: r = 34'sd4096;
      19: r = 34'sd2048;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/qte_front.sv
// front stages: component products, matrix terms, sine saturation and radicand
module qte_front import qte_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic signed [QW-1:0] quat_w_i,
  input  logic signed [QW-1:0] quat_x_i,
  input  logic signed [QW-1:0] quat_y_i,
  input  logic signed [QW-1:0] quat_z_i,
  output logic                 valid_o,
  output terms_t               terms_o,
  output logic [RADW-1:0]      rad_o
);

  logic [2:0] valid_q;
  logic signed [PW-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  terms_t terms_d, terms_q, terms2_q;
  logic [RADW-1:0] rad_d, rad_q;

  logic signed [TW-1:0] t20;
  logic signed [TW-1:0] neg_t20;
  logic [SW-2:0]        sine_mag;
  logic [2*(SW-1)-1:0]  sine_sq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ww_q <= quat_w_i * quat_w_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      wz_q <= quat_w_i * quat_z_i;
      xz_q <= quat_x_i * quat_z_i;
      wy_q <= quat_w_i * quat_y_i;
      yz_q <= quat_y_i * quat_z_i;
      wx_q <= quat_w_i * quat_x_i;
    end
  end

  always_comb begin
    terms_d.t00 = TW'(ww_q) + TW'(xx_q) - TW'(yy_q) - TW'(zz_q);
    terms_d.t22 = TW'(ww_q) - TW'(xx_q) - TW'(yy_q) + TW'(zz_q);
    terms_d.t10 = (TW'(xy_q) + TW'(wz_q)) <<< 1;
    terms_d.t21 = (TW'(yz_q) + TW'(wx_q)) <<< 1;
    t20         = (TW'(xz_q) - TW'(wy_q)) <<< 1;
    neg_t20     = -t20;
    // saturate the asin argument to plus or minus one
    if (neg_t20 > TW'(OneQ28)) begin
      terms_d.sine    = OneQ28;
      terms_d.clipped = 1'b1;
    end else if (neg_t20 < -TW'(OneQ28)) begin
      terms_d.sine    = -OneQ28;
      terms_d.clipped = 1'b1;
    end else begin
      terms_d.sine    = SW'(neg_t20);
      terms_d.clipped = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      terms_q <= terms_d;
    end
  end

  always_comb begin
    sine_mag = terms_q.sine[SW-1] ? (SW-1)'(-terms_q.sine) : (SW-1)'(terms_q.sine);
    sine_sq  = sine_mag * sine_mag;
    // one minus sine squared, in q56
    rad_d    = (RADW'(1) << (RADW - 1)) - RADW'(sine_sq);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      terms2_q <= terms_q;
      rad_q    <= rad_d;
    end
  end

  assign valid_o = valid_q[2];
  assign terms_o = terms2_q;
  assign rad_o   = rad_q;

endmodule

// File: rtl/qte_isqrt.sv
// pipelined floor integer square root, one result bit per stage
module qte_isqrt import qte_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [RADW-1:0]  rad_i,
  output logic             valid_o,
  output logic [ROOTW-1:0] root_o
);

  logic [SQRT_STEPS-1:0] valid_q;
  logic [RADW-1:0]       rem_q  [SQRT_STEPS];
  logic [RADW-1:0]       root_q [SQRT_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[SQRT_STEPS-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [RADW-1:0] StepBit = RADW'(1) << (RADW - 1 - 2 * k);
    logic [RADW-1:0] rem_in, root_in;
    logic [RADW:0]   trial;
    logic [RADW-1:0] rem_d, root_d;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    always_comb begin
      trial = {1'b0, root_in} + {1'b0, StepBit};
      if ({1'b0, rem_in} >= trial) begin
        rem_d  = RADW'({1'b0, rem_in} - trial);
        root_d = (root_in >> 1) + StepBit;
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign valid_o = valid_q[SQRT_STEPS-1];
  assign root_o  = root_q[SQRT_STEPS-1][ROOTW-1:0];

endmodule

// File: rtl/qte_atan2.sv
// pipelined atan2: special cases, normalize, quadrant fold, cordic vectoring, rounding
module qte_atan2 import qte_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic signed [TW-1:0] y_i,
  input  logic signed [TW-1:0] x_i,
  output logic                 valid_o,
  output logic signed [AW-1:0] angle_o
);

  localparam int MW = NW - 1;
  localparam int RW = ZW - 16;

  logic [ATAN_LAT-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[ATAN_LAT-2:0], valid_i};
    end
  end

  // stage a: classify and take the larger magnitude
  atan_kind_e           kind_d, kind_a_q, kind_b_q, kind_c_q, kind_q_q;
  logic [TW-1:0]        mag_x, mag_y;
  logic signed [NW-1:0] x_a_q, y_a_q, x_b_q, y_b_q, x_c_q, y_c_q;
  logic [MW-1:0]        m_a_q, m_b_q;

  always_comb begin
    mag_x = x_i[TW-1] ? TW'(-x_i) : TW'(x_i);
    mag_y = y_i[TW-1] ? TW'(-y_i) : TW'(y_i);
    if (y_i == '0 && x_i == '0) begin
      kind_d = KIND_ZERO;
    end else if (y_i == '0 && x_i[TW-1]) begin
      kind_d = KIND_PI;
    end else if (x_i == '0) begin
      kind_d = y_i[TW-1] ? KIND_NEG_HALF : KIND_POS_HALF;
    end else begin
      kind_d = KIND_CORDIC;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      kind_a_q <= kind_d;
      x_a_q    <= NW'(x_i);
      y_a_q    <= NW'(y_i);
      m_a_q    <= (mag_x > mag_y) ? MW'(mag_x) : MW'(mag_y);
    end
  end

  // stages b and c: bring the leading one of the larger magnitude to bit 38
  logic signed [NW-1:0] x_b_d, y_b_d, x_c_d, y_c_d;
  logic [MW-1:0]        m_b_d;

  always_comb begin
    x_b_d = x_a_q;
    y_b_d = y_a_q;
    m_b_d = m_a_q;
    for (int s = 32; s >= 8; s = s / 2) begin
      if ((m_b_d >> (MW - s)) == '0) begin
        m_b_d = m_b_d << s;
        x_b_d = x_b_d <<< s;
        y_b_d = y_b_d <<< s;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      kind_b_q <= kind_a_q;
      x_b_q    <= x_b_d;
      y_b_q    <= y_b_d;
      m_b_q    <= m_b_d;
    end
  end

  always_comb begin
    logic [MW-1:0] m_t;
    m_t   = m_b_q;
    x_c_d = x_b_q;
    y_c_d = y_b_q;
    for (int s = 4; s >= 1; s = s / 2) begin
      if ((m_t >> (MW - s)) == '0) begin
        m_t   = m_t << s;
        x_c_d = x_c_d <<< s;
        y_c_d = y_c_d <<< s;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      kind_c_q <= kind_b_q;
      x_c_q    <= x_c_d;
      y_c_q    <= y_c_d;
    end
  end

  // stage q: fold the left half-plane into the right one
  logic signed [CW-1:0] x_q_d, y_q_d, x_q_q, y_q_q;
  logic signed [ZW-1:0] z_q_d, z_q_q;

  always_comb begin
    x_q_d = CW'(x_c_q);
    y_q_d = CW'(y_c_q);
    z_q_d = '0;
    if (x_c_q[NW-1]) begin
      if (!y_c_q[NW-1]) begin
        x_q_d = CW'(y_c_q);
        y_q_d = -CW'(x_c_q);
        z_q_d = HalfPiQ30;
      end else begin
        x_q_d = -CW'(y_c_q);
        y_q_d = CW'(x_c_q);
        z_q_d = -HalfPiQ30;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      kind_q_q <= kind_c_q;
      x_q_q    <= x_q_d;
      y_q_q    <= y_q_d;
      z_q_q    <= z_q_d;
    end
  end

  // cordic vectoring stages
  logic signed [CW-1:0] cx_q [CORDIC_STEPS];
  logic signed [CW-1:0] cy_q [CORDIC_STEPS];
  logic signed [ZW-1:0] cz_q [CORDIC_STEPS];
  atan_kind_e           ck_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] StepAngle = atan_q30(i);
    logic signed [CW-1:0] x_in, y_in, x_d, y_d;
    logic signed [ZW-1:0] z_in, z_d;
    atan_kind_e           k_in;

    if (i == 0) begin : g_first
      assign x_in = x_q_q;
      assign y_in = y_q_q;
      assign z_in = z_q_q;
      assign k_in = kind_q_q;
    end else begin : g_next
      assign x_in = cx_q[i-1];
      assign y_in = cy_q[i-1];
      assign z_in = cz_q[i-1];
      assign k_in = ck_q[i-1];
    end

    always_comb begin
      if (!y_in[CW-1]) begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + StepAngle;
      end else begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - StepAngle;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        cx_q[i] <= x_d;
        cy_q[i] <= y_d;
        cz_q[i] <= z_d;
        ck_q[i] <= k_in;
      end
    end
  end

  // final stage: round q30 to q13, clamp to plus or minus pi, special cases
  logic signed [ZW:0]   z_rnd;
  logic signed [RW-1:0] r_full;
  logic signed [AW-1:0] angle_d, angle_q;

  always_comb begin
    z_rnd  = (ZW+1)'(cz_q[CORDIC_STEPS-1]) + (ZW+1)'(65536);
    r_full = z_rnd[ZW:17];
    case (ck_q[CORDIC_STEPS-1])
      KIND_ZERO:     angle_d = '0;
      KIND_PI:       angle_d = PiQ13;
      KIND_POS_HALF: angle_d = HalfPiQ13;
      KIND_NEG_HALF: angle_d = -HalfPiQ13;
      KIND_CORDIC: begin
        if (r_full > RW'(PiQ13)) begin
          angle_d = PiQ13;
        end else if (r_full < -RW'(PiQ13)) begin
          angle_d = -PiQ13;
        end else begin
          angle_d = AW'(r_full);
        end
      end
      default:       angle_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      angle_q <= angle_d;
    end
  end

  assign valid_o = valid_q[ATAN_LAT-1];
  assign angle_o = angle_q;

endmodule

// File: rtl/quaternion_to_euler_angles.sv
// quaternion to zyx euler angles: top level pipeline
//
//   channel | handshake                | payload
//   --------+--------------------------+------------------------------------------
//   in      | in_valid_i / in_ready_o  | quat_w_i, quat_x_i, quat_y_i, quat_z_i
//   out     | out_valid_o / out_ready_i| pitch_x_angle_o, yaw_y_angle_o,
//           |                          | roll_z_angle_o, sine_clipped_o
//
// one quaternion is taken per cycle while in_ready_o is high; each result passes through
// 3 front stages, 29 square root stages and 25 atan2 stages with 20 cordic steps.
// reset clears only the stage valid bits; no state is kept between items.
// a stalled result freezes the whole pipeline in place; in_ready_o falls only while
// the output holds a result that is not taken.
module quaternion_to_euler_angles import qte_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [QW-1:0]   quat_w_i,
  input  logic signed [QW-1:0]   quat_x_i,
  input  logic signed [QW-1:0]   quat_y_i,
  input  logic signed [QW-1:0]   quat_z_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [AW-1:0]   pitch_x_angle_o,
  output logic signed [YAWW-1:0] yaw_y_angle_o,
  output logic signed [AW-1:0]   roll_z_angle_o,
  output logic                   sine_clipped_o
);

  logic adv;
  logic front_valid, sqrt_valid, pitch_valid, yaw_valid, roll_valid;
  terms_t            front_terms;
  logic [RADW-1:0]   front_rad;
  logic [ROOTW-1:0]  root;
  terms_t            terms_dly_q [SQRT_STEPS];
  logic [ATAN_LAT-1:0] clip_dly_q;
  logic signed [AW-1:0] pitch, yaw_full, roll;

  assign out_valid_o = pitch_valid & yaw_valid & roll_valid;
  // the whole pipeline moves unless a finished result waits
  assign adv         = !out_valid_o || out_ready_i;
  assign in_ready_o  = adv;

  qte_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (in_valid_i),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .valid_o  (front_valid),
    .terms_o  (front_terms),
    .rad_o    (front_rad)
  );

  qte_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (front_valid),
    .rad_i   (front_rad),
    .valid_o (sqrt_valid),
    .root_o  (root)
  );

  // matrix terms ride alongside the square root stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      terms_dly_q[0] <= front_terms;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        terms_dly_q[k] <= terms_dly_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      clip_dly_q <= {clip_dly_q[ATAN_LAT-2:0], terms_dly_q[SQRT_STEPS-1].clipped};
    end
  end

  qte_atan2 u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (sqrt_valid),
    .y_i     (terms_dly_q[SQRT_STEPS-1].t21),
    .x_i     (terms_dly_q[SQRT_STEPS-1].t22),
    .valid_o (pitch_valid),
    .angle_o (pitch)
  );

  qte_atan2 u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (sqrt_valid),
    .y_i     (TW'(terms_dly_q[SQRT_STEPS-1].sine)),
    .x_i     ({{(TW-ROOTW){1'b0}}, root}),
    .valid_o (yaw_valid),
    .angle_o (yaw_full)
  );

  qte_atan2 u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (sqrt_valid),
    .y_i     (terms_dly_q[SQRT_STEPS-1].t10),
    .x_i     (terms_dly_q[SQRT_STEPS-1].t00),
    .valid_o (roll_valid),
    .angle_o (roll)
  );

  always_comb begin
    if (yaw_full > HalfPiQ13) begin
      yaw_y_angle_o = YAWW'(HalfPiQ13);
    end else if (yaw_full < -HalfPiQ13) begin
      yaw_y_angle_o = YAWW'(-HalfPiQ13);
    end else begin
      yaw_y_angle_o = YAWW'(yaw_full);
    end
  end

  assign pitch_x_angle_o = pitch;
  assign roll_z_angle_o  = roll;
  assign sine_clipped_o  = clip_dly_q[ATAN_LAT-1];

endmodule

// File: tb/testbench.sv
// self-checking testbench for the quaternion to euler angle pipeline
module testbench import qte_pkg::*; ();

  typedef struct packed {
    logic signed [AW-1:0]   pitch;
    logic signed [YAWW-1:0] yaw;
    logic signed [AW-1:0]   roll;
    logic                   clipped;
  } angles_t;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
    logic                 known;
    angles_t              angles;
  } quat_row_t;

  localparam int  NumRandom  = 800;
  localparam int  StallLimit = 5000;
  localparam int  DrainWait  = 80;
  localparam longint NormLimit = 64'sd274877906944;
  localparam longint OneQ28L   = 64'sd268435456;

  // directed rows; angles are typed in only where the answer is exact
  localparam quat_row_t DirRows[16] = '{
    '{16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 1'b1,
      '{16'sd0, 15'sd12868, 16'sd0, 1'b1}},
    '{16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 1'b1,
      '{16'sd0, -15'sd12868, 16'sd0, 1'b1}},
    '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
    '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
    '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
    '{16'sd16384, 16'sd0, 16'sd8192, 16'sd0, 1'b0, '0},
    '{16'sd16384, 16'sd0, -16'sd8192, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0, '0},
    '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0, '0},
    '{16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 1'b0, '0},
    '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
    '{-16'sd1, 16'sd1, -16'sd1, 16'sd1, 1'b0, '0},
    '{16'sd16384, -16'sd16384, 16'sd0, 16'sd0, 1'b0, '0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic signed [QW-1:0]   quat_w_i, quat_x_i, quat_y_i, quat_z_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic signed [AW-1:0]   pitch_x_angle_o;
  logic signed [YAWW-1:0] yaw_y_angle_o;
  logic signed [AW-1:0]   roll_z_angle_o;
  logic                   sine_clipped_o;

  angles_t pending_angles[$];
  int      mismatches = 0;
  int      stall_cycles = 0;
  int      send_idle_pct = 38;
  int      recv_idle_pct = 52;

  quaternion_to_euler_angles u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .quat_w_i, .quat_x_i, .quat_y_i, .quat_z_i,
    .out_valid_o, .out_ready_i,
    .pitch_x_angle_o, .yaw_y_angle_o, .roll_z_angle_o, .sine_clipped_o
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // vectoring cordic, q30 angle rounded to q13
  function automatic longint cordic_angle(longint ay, longint ax);
    longint zq, tmp, dx, dy, r;
    int     n;
    zq = 0;
    if (ay == 0 && ax == 0) return 0;
    if (ay == 0 && ax < 0) return PiQ13;
    if (ax == 0) return (ay > 0) ? HalfPiQ13 : -HalfPiQ13;
    for (n = 0; n < 48 && (ax < 0 ? -ax : ax) < NormLimit &&
         (ay < 0 ? -ay : ay) < NormLimit; n++) begin
      ax *= 2;
      ay *= 2;
    end
    if (ax < 0) begin
      tmp = ax;
      if (ay >= 0) begin
        ax = ay;  ay = -tmp; zq = HalfPiQ30;
      end else begin
        ax = -ay; ay = tmp;  zq = -HalfPiQ30;
      end
    end
    for (n = 0; n < CORDIC_STEPS; n++) begin
      dx = floor_shift(ay, n);
      dy = floor_shift(ax, n);
      if (ay >= 0) begin
        ax += dx; ay -= dy; zq += atan_q30(n);
      end else begin
        ax -= dx; ay += dy; zq -= atan_q30(n);
      end
    end
    r = floor_shift(zq + 65536, 17);
    if (r > PiQ13) r = PiQ13;
    if (r < -PiQ13) r = -PiQ13;
    return r;
  endfunction

  function automatic angles_t euler_from_quat(logic signed [QW-1:0] qw,
      logic signed [QW-1:0] qx, logic signed [QW-1:0] qy, logic signed [QW-1:0] qz);
    longint  w, x, y, z, t00, t10, t20, t21, t22, s, c, yaw;
    angles_t a;
    w = qw; x = qx; y = qy; z = qz;
    t00 = w*w + x*x - y*y - z*z;
    t10 = 2 * (x*y + w*z);
    t20 = 2 * (x*z - w*y);
    t21 = 2 * (y*z + w*x);
    t22 = w*w - x*x - y*y + z*z;
    s = -t20;
    a.clipped = 1'b0;
    if (s > OneQ28L) begin s = OneQ28L; a.clipped = 1'b1; end
    if (s < -OneQ28L) begin s = -OneQ28L; a.clipped = 1'b1; end
    c = longint'(root_floor($unsigned(OneQ28L * OneQ28L - s * s)));
    yaw = cordic_angle(s, c);
    if (yaw > HalfPiQ13) yaw = HalfPiQ13;
    if (yaw < -HalfPiQ13) yaw = -HalfPiQ13;
    a.pitch = AW'(cordic_angle(t21, t22));
    a.yaw   = YAWW'(yaw);
    a.roll  = AW'(cordic_angle(t10, t00));
    return a;
  endfunction

  // component biased toward unit-sized and boundary values
  function automatic logic signed [QW-1:0] pick_component();
    case ($urandom_range(0, 9))
      0:       return 16'sd0;
      1:       return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      2:       return $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
      3, 4, 5: return QW'($signed($urandom_range(0, 32768)) - 16384);
      6:       return QW'($signed($urandom_range(0, 64)) - 32);
      default: return QW'($urandom);
    endcase
  endfunction

  task automatic send_quat(quat_row_t row);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    quat_w_i   <= row.w;
    quat_x_i   <= row.x;
    quat_y_i   <= row.y;
    quat_z_i   <= row.z;
    do @(posedge clk_i); while (!in_ready_o);
    pending_angles.push_back(row.known ? row.angles
                                       : euler_from_quat(row.w, row.x, row.y, row.z));
    @(negedge clk_i);
  endtask

  initial begin
    quat_row_t row;
    int        phase;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    quat_w_i    = '0;
    quat_x_i    = '0;
    quat_y_i    = '0;
    quat_z_i    = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (DirRows[r]) send_quat(DirRows[r]);
    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle_pct = 52; recv_idle_pct = 38; end
      if (phase == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      repeat (NumRandom / 3) begin
        row       = '0;
        row.w     = pick_component();
        row.x     = pick_component();
        row.y     = pick_component();
        row.z     = pick_component();
        send_quat(row);
      end
    end
    in_valid_i <= 1'b0;
    while (pending_angles.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver stalls at random, sometimes for long stretches not at all
  initial out_ready_i = 1'b0;
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    angles_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_angles.size() == 0) begin
        $error("result transfer with no quaternion outstanding");
        mismatches++;
      end else begin
        want = pending_angles.pop_front();
        if (pitch_x_angle_o !== want.pitch) begin
          $error("pitch_x_angle expected %0d got %0d", want.pitch, pitch_x_angle_o);
          mismatches++;
        end
        if (yaw_y_angle_o !== want.yaw) begin
          $error("yaw_y_angle expected %0d got %0d", want.yaw, yaw_y_angle_o);
          mismatches++;
        end
        if (roll_z_angle_o !== want.roll) begin
          $error("roll_z_angle expected %0d got %0d", want.roll, roll_z_angle_o);
          mismatches++;
        end
        if (sine_clipped_o !== want.clipped) begin
          $error("sine_clipped expected %0d got %0d", want.clipped, sine_clipped_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
